// ===== hw/rtl/teadec_pkg.sv =====
`default_nettype none
package teadec_pkg;

    // cipher constants
    localparam logic [31:0] DELTA     = 32'h9E37_79B9;
    localparam logic [31:0] SUM_START = 32'hC6EF_3720;
    localparam int unsigned CYCLES    = 32;
    localparam int unsigned STEP_W    = $clog2(CYCLES);

    // configuration register indexes
    localparam logic [1:0] KEY_WORD_0_IDX = 2'd0;
    localparam logic [1:0] KEY_WORD_1_IDX = 2'd1;
    localparam logic [1:0] KEY_WORD_2_IDX = 2'd2;
    localparam logic [1:0] KEY_WORD_3_IDX = 2'd3;

    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } key_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    // running sum seen by round number idx of a pass
    function automatic logic [31:0] round_sum(input int unsigned idx);
        logic [31:0] prod;
        prod = 32'(idx) * DELTA;
        return SUM_START - prod;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/teadec_cell.sv =====
`default_nettype none
module teadec_cell (
    input  wire logic              aclk,
    input  wire teadec_pkg::key_t  key,
    input  wire logic [31:0]       round_sum,
    input  wire logic [31:0]       in_left,
    input  wire logic [31:0]       in_right,
    output logic [31:0]            out_left,
    output logic [31:0]            out_right
);

    logic [31:0] left_reg,  left_next;
    logic [31:0] right_reg, right_next;

    // one decryption round: right half first, then left half
    always_comb begin
        right_next = in_right - (((in_left << 4) + key.w2) ^ (in_left + round_sum)
                                 ^ ((in_left >> 5) + key.w3));
        left_next  = in_left - (((right_next << 4) + key.w0) ^ (right_next + round_sum)
                                ^ ((right_next >> 5) + key.w1));
    end

    // hand the halves to the next cell
    always_ff @(posedge aclk) begin
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    assign out_left  = left_reg;
    assign out_right = right_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/tea_block_decrypt_repeated_core.sv =====
// Repeated TEA block decryption core.
//
// Input channel (s_valid/s_ready): one transaction carries the two 32-bit
// ciphertext halves and a 16-bit repeat count. Result channel
// (m_valid/m_ready): one transaction with both plaintext halves. The user
// is to write the key through cfg_wr_en/cfg_index/cfg_wr_data while idle; the
// core itself does not enforce this.
// A row of 32 round cells carries the block one cell per clock, and the
// block re-enters the first cell for every further pass. For a repeat
// count N > 0 the block makes N passes and then goes through the holding
// register to the output register; for N = 0 the ciphertext goes straight
// to the holding register. One block is in the row at a time, so the next
// transaction is taken once the current result has left the holding register.
//
// Reset (synchronous, aresetn low) clears the key words and all control
// state; no result is pending afterwards. When the receiver stalls, the
// result waits in the output register and a second result waits in a
// holding register; the core takes a new transaction only when the holding
// register is free.
`default_nettype none
module tea_block_decrypt_repeated_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wr_data,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_cipher_left,
    input  wire logic [31:0] s_cipher_right,
    input  wire logic [15:0] s_repeat_count,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_plain_left,
    output logic [31:0]      m_plain_right
);

    localparam int unsigned NCELL = teadec_pkg::CYCLES;
    localparam logic [teadec_pkg::STEP_W-1:0] LAST_STEP = teadec_pkg::STEP_W'(NCELL - 1);

    teadec_pkg::key_t key_reg;
    teadec_pkg::state_t state_reg, state_next;

    logic [teadec_pkg::STEP_W-1:0] step_reg, step_next;
    logic [15:0] pass_reg, pass_next;
    logic [31:0] hold_left_reg, hold_right_reg;
    logic        m_valid_reg;
    logic [31:0] out_left_reg, out_right_reg;

    logic accept;
    logic out_free;
    logic pass_end;
    logic load_hold;
    logic move_out;

    logic [31:0] chain_left  [NCELL+1];
    logic [31:0] chain_right [NCELL+1];

    // key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                teadec_pkg::KEY_WORD_0_IDX: key_reg.w0 <= cfg_wr_data;
                teadec_pkg::KEY_WORD_1_IDX: key_reg.w1 <= cfg_wr_data;
                teadec_pkg::KEY_WORD_2_IDX: key_reg.w2 <= cfg_wr_data;
                teadec_pkg::KEY_WORD_3_IDX: key_reg.w3 <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // row of round cells; the first cell takes new input or the recirculated block
    assign chain_left[0]  = (state_reg == teadec_pkg::ST_IDLE) ? s_cipher_left
                                                               : chain_left[NCELL];
    assign chain_right[0] = (state_reg == teadec_pkg::ST_IDLE) ? s_cipher_right
                                                               : chain_right[NCELL];

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        teadec_cell u_cell (
            .aclk      (aclk),
            .key       (key_reg),
            .round_sum (teadec_pkg::round_sum(i)),
            .in_left   (chain_left[i]),
            .in_right  (chain_right[i]),
            .out_left  (chain_left[i+1]),
            .out_right (chain_right[i+1])
        );
    end

    assign out_free = !m_valid_reg || m_ready;
    assign pass_end = (state_reg == teadec_pkg::ST_RUN) && (step_reg == LAST_STEP);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            teadec_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_repeat_count == 16'd0) ? teadec_pkg::ST_HOLD
                                                           : teadec_pkg::ST_RUN;
                end
            end
            teadec_pkg::ST_RUN: begin
                if (pass_end && pass_reg == 16'd1) begin
                    state_next = teadec_pkg::ST_HOLD;
                end
            end
            teadec_pkg::ST_HOLD: begin
                if (out_free) begin
                    state_next = teadec_pkg::ST_IDLE;
                end
            end
            default: state_next = teadec_pkg::ST_IDLE;
        endcase
    end

    // state machine outputs
    always_comb begin
        s_ready   = 1'b0;
        load_hold = 1'b0;
        move_out  = 1'b0;
        step_next = step_reg + 1'b1;
        pass_next = pass_reg;
        case (state_reg)
            teadec_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                step_next = '0;
                pass_next = s_repeat_count;
                load_hold = s_valid && (s_repeat_count == 16'd0);
            end
            teadec_pkg::ST_RUN: begin
                if (pass_end) begin
                    step_next = '0;
                    pass_next = pass_reg - 16'd1;
                    load_hold = (pass_reg == 16'd1);
                end
            end
            teadec_pkg::ST_HOLD: begin
                move_out = out_free;
            end
            default: ;
        endcase
    end

    assign accept = s_valid && s_ready;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= teadec_pkg::ST_IDLE;
            step_reg    <= '0;
            pass_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pass_reg  <= pass_next;
            if (move_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // holding and output data
    always_ff @(posedge aclk) begin
        if (load_hold) begin
            if (state_reg == teadec_pkg::ST_IDLE) begin
                hold_left_reg  <= s_cipher_left;
                hold_right_reg <= s_cipher_right;
            end else begin
                hold_left_reg  <= chain_left[NCELL];
                hold_right_reg <= chain_right[NCELL];
            end
        end
        if (move_out) begin
            out_left_reg  <= hold_left_reg;
            out_right_reg <= hold_right_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_plain_left  = out_left_reg;
    assign m_plain_right = out_right_reg;

    // checks
    a_run_has_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == teadec_pkg::ST_RUN) |-> (pass_reg != 16'd0))
        else $error("running with no pass left");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == teadec_pkg::ST_RUN && step_reg != LAST_STEP)
        |=> (state_reg == teadec_pkg::ST_RUN))
        else $error("pass left the row early");

    a_hold_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        move_out |=> (m_valid_reg && state_reg == teadec_pkg::ST_IDLE))
        else $error("held result not moved to output");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != teadec_pkg::ST_IDLE))
        else $error("transaction accepted without starting work");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
module tb;

    // receiver hold-off used to back the core up
    localparam int unsigned LONG_HOLD_CYCLES = 400;

    // one plaintext result transaction
    typedef struct {
        logic [31:0] left;
        logic [31:0] right;
    } plain_block_t;

    // predicts the repeated decryption and checks results in order
    class plaintext_scoreboard;
        logic [31:0]  key_words [4];
        plain_block_t pending_plain [$];
        int unsigned  error_count;

        function new();
            for (int i = 0; i < 4; i++) key_words[i] = '0;
            error_count = 0;
        endfunction

        function void set_key_word(logic [1:0] idx, logic [31:0] value);
            key_words[idx] = value;
        endfunction

        // full tea decryption applied count times, sum restarts every pass
        function plain_block_t decrypt_repeated(logic [31:0] left, logic [31:0] right,
                                                logic [15:0] count);
            logic [31:0]  a;
            logic [31:0]  b;
            logic [31:0]  s;
            plain_block_t res;
            a = left;
            b = right;
            for (int unsigned n = 0; n < count; n++) begin
                s = teadec_pkg::SUM_START;
                for (int unsigned c = 0; c < teadec_pkg::CYCLES; c++) begin
                    b = b - (((a << 4) + key_words[teadec_pkg::KEY_WORD_2_IDX]) ^ (a + s) ^
                             ((a >> 5) + key_words[teadec_pkg::KEY_WORD_3_IDX]));
                    a = a - (((b << 4) + key_words[teadec_pkg::KEY_WORD_0_IDX]) ^ (b + s) ^
                             ((b >> 5) + key_words[teadec_pkg::KEY_WORD_1_IDX]));
                    s = s - teadec_pkg::DELTA;
                end
            end
            res.left  = a;
            res.right = b;
            return res;
        endfunction

        function void note_block(logic [31:0] left, logic [31:0] right, logic [15:0] count);
            pending_plain.push_back(decrypt_repeated(left, right, count));
        endfunction

        function void check_block(logic [31:0] left, logic [31:0] right);
            plain_block_t exp_blk;
            if (pending_plain.size() == 0) begin
                $error("unexpected result: plain_left %h plain_right %h", left, right);
                error_count++;
                return;
            end
            exp_blk = pending_plain.pop_front();
            if (left !== exp_blk.left) begin
                $error("plain_left mismatch: expected %h, actual %h", exp_blk.left, left);
                error_count++;
            end
            if (right !== exp_blk.right) begin
                $error("plain_right mismatch: expected %h, actual %h", exp_blk.right, right);
                error_count++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_plain.size();
        endfunction
    endclass

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_cipher_left;
    logic [31:0] s_cipher_right;
    logic [15:0] s_repeat_count;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_plain_left;
    logic [31:0] m_plain_right;

    logic        steady_flow  = 1'b0;
    logic        hold_off_req = 1'b0;
    logic        hold_active  = 1'b0;

    plaintext_scoreboard sb;

    tea_block_decrypt_repeated_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cipher_left  (s_cipher_left),
        .s_cipher_right (s_cipher_right),
        .s_repeat_count (s_repeat_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_plain_left   (m_plain_left),
        .m_plain_right  (m_plain_right)
    );

    // clock
    always #2 aclk = ~aclk;

    // gap length: mostly short, a few long, none during steady flow
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // repeat counts stay small so passes stay short
    function automatic logic [15:0] random_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'd0;
        if (r < 70) return 16'($urandom_range(1, 3));
        if (r < 95) return 16'($urandom_range(4, 15));
        return 16'($urandom_range(16, 127));
    endfunction

    function automatic logic [31:0] random_half();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom();
    endfunction

    // record every accepted input transaction
    always @(posedge aclk) begin
        if (aresetn && s_valid === 1'b1 && s_ready === 1'b1) begin
            sb.note_block(s_cipher_left, s_cipher_right, s_repeat_count);
        end
    end

    // check every accepted result transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            sb.check_block(m_plain_left, m_plain_right);
        end
    end

    // result receiver with random stalls and one long hold-off on request
    initial begin : result_sink
        int unsigned span;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready      <= 1'b0;
                hold_active  <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                m_ready     <= 1'b1;
                hold_active <= 1'b0;
            end else begin
                span = pick_gap();
                if (span == 0) begin
                    m_ready <= 1'b1;
                    span = $urandom_range(1, 8);
                end else begin
                    m_ready <= 1'b0;
                end
                repeat (span - 1) @(negedge aclk);
            end
        end
    end

    // offer one input transaction and wait until it is taken; call at a falling edge
    task automatic send_block(input logic [31:0] left, input logic [31:0] right,
                              input logic [15:0] count);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_cipher_left  <= left;
        s_cipher_right <= right;
        s_repeat_count <= count;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    task automatic send_random_blocks(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            send_block(random_half(), random_half(), random_count());
        end
    endtask

    // write all four key words on consecutive cycles
    task automatic load_key(input logic [31:0] w0, input logic [31:0] w1,
                            input logic [31:0] w2, input logic [31:0] w3);
        logic [31:0] words [4];
        logic [1:0]  idx_list [4];
        words[0] = w0;
        words[1] = w1;
        words[2] = w2;
        words[3] = w3;
        idx_list[0] = teadec_pkg::KEY_WORD_0_IDX;
        idx_list[1] = teadec_pkg::KEY_WORD_1_IDX;
        idx_list[2] = teadec_pkg::KEY_WORD_2_IDX;
        idx_list[3] = teadec_pkg::KEY_WORD_3_IDX;
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idx_list[i];
            cfg_wr_data <= words[i];
            sb.set_key_word(idx_list[i], words[i]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // stop offering and wait until every result is back and the core is idle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // main stimulus
    initial begin : stimulus
        sb = new();
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_cipher_left  = '0;
        s_cipher_right = '0;
        s_repeat_count = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // zero key from reset: zero count returns the block as is
        send_block('0, '0, 16'd0);
        send_block('1, '1, 16'd0);
        send_block($urandom(), $urandom(), 16'd0);
        send_block('0, '0, 16'd1);
        send_block('1, '1, 16'd1);
        send_block('1, '0, 16'd2);
        drain_results();

        // all-ones key
        load_key('1, '1, '1, '1);
        send_block('0, '1, 16'd1);
        send_block('1, '1, 16'd1);
        send_block($urandom(), $urandom(), 16'd3);
        send_block($urandom(), $urandom(), 16'd0);
        drain_results();

        // random key, largest repeat count once
        load_key($urandom(), $urandom(), $urandom(), $urandom());
        send_block($urandom(), $urandom(), 16'hFFFF);
        send_block($urandom(), $urandom(), 16'd32);
        send_block($urandom(), $urandom(), 16'd1);
        drain_results();

        // random traffic under several keys
        load_key($urandom(), $urandom(), $urandom(), $urandom());
        send_random_blocks(100);
        drain_results();

        load_key('0, '0, '0, '0);
        send_random_blocks(70);
        drain_results();

        // receiver holds off while the sender keeps offering transactions
        load_key($urandom(), $urandom(), $urandom(), $urandom());
        steady_flow  <= 1'b1;
        hold_off_req <= 1'b1;
        do @(negedge aclk); while (!hold_active);
        hold_off_req <= 1'b0;
        for (int i = 0; i < 12; i++) begin
            send_block($urandom(), $urandom(), 16'($urandom_range(0, 2)));
        end
        steady_flow <= 1'b0;
        send_random_blocks(60);
        drain_results();

        // mixed extremes with no idling on either side
        load_key('1, '0, $urandom(), '1);
        steady_flow <= 1'b1;
        send_random_blocks(90);
        drain_results();
        steady_flow <= 1'b0;

        load_key($urandom(), $urandom(), $urandom(), $urandom());
        send_random_blocks(110);
        drain_results();

        // watch for stray results
        repeat (64) @(negedge aclk);
        if (sb.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog: ends the run if the stimulus hangs
    initial begin : watchdog
        #64_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/teadec_pkg.sv
hw/rtl/teadec_cell.sv
hw/rtl/tea_block_decrypt_repeated_core.sv
verif/tb.sv
